@@ rtl/ptda_pkg.sv @@
package ptda_pkg;

  // Fixed-point format and datapath widths.
  localparam int FracBits   = 16;
  localparam int DataW      = 32;
  localparam int DeadZoneW  = 31;
  localparam int CfgIdxW    = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_INTEGRAL_GAIN = 3'd1,
    CFG_TRIM_LOW      = 3'd2,
    CFG_TRIM_HIGH     = 3'd3,
    CFG_DEAD_ZONE     = 3'd4
  } ptda_cfg_idx_e;

  // Register reset values.
  localparam logic [DataW-1:0]        PropGainRst     = 32'd6554;
  localparam logic [DataW-1:0]        IntegralGainRst = 32'd0;
  localparam logic signed [DataW-1:0] TrimLowRst      = -32'sd19661;
  localparam logic signed [DataW-1:0] TrimHighRst     = 32'sd19661;
  localparam logic [DeadZoneW-1:0]    DeadZoneRst     = 31'd66;

  // Input beat.
  typedef struct packed {
    logic signed [DataW-1:0] target_quality;
    logic signed [DataW-1:0] measured_quality;
  } ptda_in_t;

  // Output beat.
  typedef struct packed {
    logic signed [DataW-1:0] trim_value;
    logic                    is_saturated;
    logic                    in_dead_zone;
  } ptda_out_t;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic signed [DataW-1:0] err;
    logic                    frozen;
  } ptda_cmd_t;

  // Configuration register file.
  typedef struct packed {
    logic        [DataW-1:0]     prop_gain;
    logic        [DataW-1:0]     integral_gain;
    logic signed [DataW-1:0]     trim_low;
    logic signed [DataW-1:0]     trim_high;
    logic        [DeadZoneW-1:0] dead_zone;
  } ptda_cfg_t;

endpackage

@@ rtl/ptda_front.sv @@
module ptda_front import ptda_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ptda_in_t             in_data_i,
  input  logic [DeadZoneW-1:0] dead_zone_i,
  input  logic                 full_i,
  output logic                 push_o,
  output ptda_cmd_t            push_data_o
);

  logic                    valid_q, valid_d;
  logic signed [DataW-1:0] err_q, err_d;
  logic        [DataW:0]   diff;
  logic        [DataW-1:0] mag;
  logic                    accept;

  // The stage takes a new beat whenever its contents move on to the queue.
  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;

  // Error is setpoint minus measurement, saturated to 32 bits.
  always_comb begin
    diff = {in_data_i.target_quality[DataW-1], in_data_i.target_quality}
         - {in_data_i.measured_quality[DataW-1], in_data_i.measured_quality};
    if (diff[DataW] != diff[DataW-1]) begin
      err_d = diff[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      err_d = diff[DataW-1:0];
    end
  end

  // Dead zone check on the registered error; the most negative error has magnitude 2^31.
  always_comb begin
    mag = err_q[DataW-1] ? (~err_q + 1'b1) : err_q;
    push_data_o.err    = err_q;
    push_data_o.frozen = mag < {1'b0, dead_zone_i};
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= err_d;
    end
  end

endmodule

@@ rtl/ptda_queue.sv @@
module ptda_queue import ptda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ptda_cmd_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output ptda_cmd_t pop_data_o
);

  ptda_cmd_t              entries_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;

  assign full_o     = count_q == QueueCntW'(QueueDepth);
  assign empty_o    = count_q == '0;
  assign pop_data_o = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/ptda_back.sv @@
module ptda_back import ptda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ptda_cfg_t cfg_i,
  input  logic      empty_i,
  input  ptda_cmd_t pop_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ptda_out_t out_data_o
);

  localparam int ProdW = 2 * DataW + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_SCALE  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_SUM    = 5'b10000
  } ptda_state_e;

  // Saturate a shifted product to 32 bits.
  function automatic logic signed [DataW-1:0] sat_prod(input logic signed [ProdW-1:0] v);
    logic ok;
    ok = (&v[ProdW-1:DataW-1]) || !(|v[ProdW-1:DataW-1]);
    if (ok) begin
      sat_prod = v[DataW-1:0];
    end else begin
      sat_prod = v[ProdW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

  // Saturate a two-term sum to 32 bits.
  function automatic logic signed [DataW-1:0] sat_sum(input logic signed [DataW+1:0] v);
    logic ok;
    ok = (&v[DataW+1:DataW-1]) || !(|v[DataW+1:DataW-1]);
    if (ok) begin
      sat_sum = v[DataW-1:0];
    end else begin
      sat_sum = v[DataW+1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

  ptda_state_e             state_q, state_d;
  logic signed [DataW-1:0] err_q;
  logic                    frozen_q;
  logic signed [ProdW-1:0] prod_p_q, prod_i_q;
  logic signed [DataW-1:0] p_q, di_q;
  logic signed [DataW-1:0] integ_q, integ_d;
  logic signed [DataW-1:0] held_q;
  logic                    sat_q;
  logic                    out_valid_q, out_valid_d;
  ptda_out_t               out_q, result;
  logic                    done, out_free;

  logic signed [ProdW-1:0] prod_p_d, prod_i_d, shift_p, shift_i;
  logic signed [DataW+1:0] proposed;
  logic signed [DataW+2:0] prop_out;
  logic signed [DataW+1:0] sum;
  logic                    err_pos, err_neg, skip;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign done        = (state_q == ST_SUM) && out_free;
  assign pop_o       = !empty_i && ((state_q == ST_IDLE) || done);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Gain products, exact 65-bit signed.
  assign prod_p_d = $signed({1'b0, cfg_i.prop_gain}) * $signed({err_q[DataW-1], err_q});
  assign prod_i_d = $signed({1'b0, cfg_i.integral_gain}) * $signed({err_q[DataW-1], err_q});

  // Arithmetic shift rounds toward minus infinity.
  assign shift_p = prod_p_q >>> FracBits;
  assign shift_i = prod_i_q >>> FracBits;

  // Conditional integration: skip the step if it drives the output past the limit on the error's side.
  always_comb begin
    err_pos  = !err_q[DataW-1] && (|err_q);
    err_neg  = err_q[DataW-1];
    proposed = {{2{integ_q[DataW-1]}}, integ_q} + {{2{di_q[DataW-1]}}, di_q};
    prop_out = {{3{p_q[DataW-1]}}, p_q} + {proposed[DataW+1], proposed};
    skip     = (prop_out > $signed({{3{cfg_i.trim_high[DataW-1]}}, cfg_i.trim_high})
                && err_pos)
            || (prop_out < $signed({{3{cfg_i.trim_low[DataW-1]}}, cfg_i.trim_low})
                && err_neg);
    integ_d  = skip ? integ_q : sat_sum(proposed);
  end

  // Output sum and clamp; a frozen item repeats the held output.
  always_comb begin
    sum = {{2{p_q[DataW-1]}}, p_q} + {{2{integ_q[DataW-1]}}, integ_q};
    if (frozen_q) begin
      result.trim_value   = held_q;
      result.is_saturated = sat_q;
      result.in_dead_zone = 1'b1;
    end else if (sum > $signed({{2{cfg_i.trim_high[DataW-1]}}, cfg_i.trim_high})) begin
      result.trim_value   = cfg_i.trim_high;
      result.is_saturated = 1'b1;
      result.in_dead_zone = 1'b0;
    end else if (sum < $signed({{2{cfg_i.trim_low[DataW-1]}}, cfg_i.trim_low})) begin
      result.trim_value   = cfg_i.trim_low;
      result.is_saturated = 1'b1;
      result.in_dead_zone = 1'b0;
    end else begin
      result.trim_value   = sum[DataW-1:0];
      result.is_saturated = 1'b0;
      result.in_dead_zone = 1'b0;
    end
  end

  // Sequencer: multiply, scale, integrator decision, output; dead zone items go straight to output.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = pop_data_i.frozen ? ST_SUM : ST_MUL;
        end
      end
      ST_MUL:    state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_SUM;
      ST_SUM: begin
        if (done) begin
          if (pop_o) begin
            state_d = pop_data_i.frozen ? ST_SUM : ST_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      held_q      <= '0;
      sat_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_DECIDE) begin
        integ_q <= integ_d;
      end
      if (done && !frozen_q) begin
        held_q <= result.trim_value;
        sat_q  <= result.is_saturated;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      err_q    <= pop_data_i.err;
      frozen_q <= pop_data_i.frozen;
    end
    if (state_q == ST_MUL) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
    end
    if (state_q == ST_SCALE) begin
      p_q  <= sat_prod(shift_p);
      di_q <= sat_prod(shift_i);
    end
    if (done) begin
      out_q <= result;
    end
  end

endmodule

@@ rtl/pi_trim_deadzone_antiwindup.sv @@
// PI trim controller with dead zone and conditional-integration anti-windup.
// Input channel: in_valid_i / in_stall_o carry a setpoint and a measurement
// in signed Q16.16; a beat is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry the clamped trim value, the
// saturated flag and the dead zone flag, one output beat per input beat, in order.
// Configuration: cfg_valid_i / cfg_ready_o with a register index and write
// data; ready is always high. Write only while the block is idle.
// An input beat passes the front register and the queue, then the back
// sequencer that multiplies, scales, decides the integrator step and
// forms the output; it takes the next beat only as it hands one out.
// Dead zone beats go from the queue straight to the output step.
// A four-entry queue between the classifying front and the back lets the
// input keep taking beats while the sequencer works or the output is stalled.
// When the receiver stalls, the output beat holds; once the queue and front
// fill, in_stall_o rises. Reset clears the integrator, the held output and the
// saturated flag, restores the default registers and empties the pipeline.
module pi_trim_deadzone_antiwindup import ptda_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptda_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptda_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_wdata_i
);

  ptda_cfg_t cfg_q;
  ptda_cmd_t push_data, pop_data;
  logic      push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= PropGainRst;
      cfg_q.integral_gain <= IntegralGainRst;
      cfg_q.trim_low      <= TrimLowRst;
      cfg_q.trim_high     <= TrimHighRst;
      cfg_q.dead_zone     <= DeadZoneRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_wdata_i;
        CFG_INTEGRAL_GAIN: cfg_q.integral_gain <= cfg_wdata_i;
        CFG_TRIM_LOW:      cfg_q.trim_low      <= cfg_wdata_i;
        CFG_TRIM_HIGH:     cfg_q.trim_high     <= cfg_wdata_i;
        CFG_DEAD_ZONE:     cfg_q.dead_zone     <= cfg_wdata_i[DeadZoneW-1:0];
        default: ;
      endcase
    end
  end

  ptda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .dead_zone_i (cfg_q.dead_zone),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ptda_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  ptda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // An unclamped computed output lies within the limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_dead_zone && !out_data_o.is_saturated |->
      (out_data_o.trim_value <= cfg_q.trim_high) && (out_data_o.trim_value >= cfg_q.trim_low))
    else $error("unclamped output outside the trim limits");

  // A clamped computed output equals one of the limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_dead_zone && out_data_o.is_saturated |->
      (out_data_o.trim_value == cfg_q.trim_high) || (out_data_o.trim_value == cfg_q.trim_low))
    else $error("saturated output is not a trim limit");

  // The queue is never pushed while full nor popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule
